FILE: sv/apor_pkg.sv
// ----------------------------------------------------------------------------
// apor_pkg
// shared constants, types and helpers of the push-out resolver
// ----------------------------------------------------------------------------
package apor_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int MAX_PASSES  = 4;
  localparam int COORD_BITS  = 24;
  localparam int OFF_BITS    = 17;
  localparam int IDX_BITS    = 6;
  localparam int PASS_BITS   = 3;
  localparam int CFG_IDX_BITS = 2;
  localparam int ADDR_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // two guard bits cover every box edge, overlap and pushed coordinate
  localparam int SUM_BITS    = COORD_BITS + 2;

  localparam logic signed [SUM_BITS-1:0] SUM_HI =
    {{(SUM_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_LO = ~SUM_HI;

  localparam logic signed [OFF_BITS-1:0] LEFT_RST  = -17'sd256;
  localparam logic [OFF_BITS-1:0]        RIGHT_RST = 17'd256;
  localparam logic signed [OFF_BITS-1:0] NEAR_RST  = -17'sd256;
  localparam logic [OFF_BITS-1:0]        FAR_RST   = 17'd256;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LEFT  = 2'd0,
    CFG_RIGHT = 2'd1,
    CFG_NEAR  = 2'd2,
    CFG_FAR   = 2'd3
  } cfg_idx_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_BITS-1:0]   wide_t;

  typedef struct packed {
    coord_t cx;
    coord_t cz;
    coord_t minx;
    coord_t maxx;
    coord_t minz;
    coord_t maxz;
  } geo_t;

  // controller to datapath
  typedef struct packed {
    logic                 wr;
    logic                 load;
    logic                 box;
    logic                 rd;
    logic [ADDR_BITS-1:0] addr;
    logic                 apply;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_empty;
    logic pass_hit;
    logic pass_last;
  } ctrl_sts_t;

  function automatic wide_t sext_coord(coord_t v);
    return SUM_BITS'(v);
  endfunction

  function automatic coord_t sat_coord(wide_t v);
    coord_t r;
    if (v > SUM_HI) begin
      r = COORD_BITS'(SUM_HI);
    end else if (v < SUM_LO) begin
      r = COORD_BITS'(SUM_LO);
    end else begin
      r = COORD_BITS'(v);
    end
    return r;
  endfunction

endpackage

FILE: sv/apor_ctrl.sv
// ----------------------------------------------------------------------------
// apor_ctrl
// sequencer: table writes, per-pass box setup, table scan, drain and push
// ----------------------------------------------------------------------------
module apor_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   in_mode,
  input  apor_pkg::ctrl_sts_t    sts,
  output apor_pkg::ctrl_cmd_t    cmd,
  output logic                   busy,
  output logic                   out_valid
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BOX   = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_APPLY = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [apor_pkg::ADDR_BITS-1:0] addr_r, addr_nxt;
  logic                          accept;
  logic                          addr_last;

  assign accept    = start && (state_r == S_IDLE);
  assign addr_last = (addr_r == apor_pkg::ADDR_BITS'(apor_pkg::TABLE_DEPTH - 1));
  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    cmd       = '0;
    cmd.addr  = addr_r;
    case (state_r)
      S_IDLE: begin
        cmd.wr   = accept && !in_mode;
        cmd.load = accept && in_mode;
        if (accept && in_mode) begin
          state_nxt = S_BOX;
        end
      end
      S_BOX: begin
        cmd.box   = 1'b1;
        addr_nxt  = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.rd   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (!sts.pass_hit || sts.pass_last) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_BOX;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

  a_done_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> $past(state_r == S_APPLY))
    else $error("result strobe without a preceding push step");

  a_apply_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |-> sts.pipe_empty)
    else $error("push applied while scan pipeline still busy");

  a_scan_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_SCAN) |-> (addr_r == '0))
    else $error("table scan did not start at slot zero");

endmodule

FILE: sv/apor_dp.sv
// ----------------------------------------------------------------------------
// apor_dp
// datapath: obstacle table, two-stage overlap pipeline, best-hit tracking
// ----------------------------------------------------------------------------
module apor_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  apor_pkg::ctrl_cmd_t                  cmd,
  output apor_pkg::ctrl_sts_t                  sts,
  input  logic                                 cfg_we,
  input  logic [apor_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [apor_pkg::OFF_BITS-1:0]        cfg_wdata,
  input  logic [apor_pkg::IDX_BITS-1:0]        in_entry_index,
  input  logic                                 in_entry_present,
  input  logic signed [apor_pkg::COORD_BITS-1:0] in_box_center_x,
  input  logic signed [apor_pkg::COORD_BITS-1:0] in_box_center_z,
  input  logic signed [apor_pkg::COORD_BITS-1:0] in_box_min_x,
  input  logic signed [apor_pkg::COORD_BITS-1:0] in_box_max_x,
  input  logic signed [apor_pkg::COORD_BITS-1:0] in_box_min_z,
  input  logic signed [apor_pkg::COORD_BITS-1:0] in_box_max_z,
  input  logic signed [apor_pkg::COORD_BITS-1:0] in_player_x,
  input  logic signed [apor_pkg::COORD_BITS-1:0] in_player_z,
  output logic signed [apor_pkg::COORD_BITS-1:0] out_resolved_x,
  output logic signed [apor_pkg::COORD_BITS-1:0] out_resolved_z,
  output logic                                 out_hit_any,
  output logic [apor_pkg::PASS_BITS-1:0]       out_passes_used
);

  // configuration
  logic signed [apor_pkg::OFF_BITS-1:0] left_r, near_r;
  logic [apor_pkg::OFF_BITS-1:0]        right_r, far_r;

  // obstacle table
  apor_pkg::geo_t                       geo_mem [apor_pkg::TABLE_DEPTH];
  logic [apor_pkg::TABLE_DEPTH-1:0]     present_r;
  logic [apor_pkg::ADDR_BITS-1:0]       waddr;
  logic                                 wr_ok;

  // player state
  apor_pkg::coord_t                     px_r, pz_r;
  logic                                 any_r;
  logic [apor_pkg::PASS_BITS-1:0]       passes_r;
  apor_pkg::coord_t                     pminx_r, pmaxx_r, pminz_r, pmaxz_r;

  // read stage
  logic                                 s1_v_r;
  apor_pkg::geo_t                       rd_q_r;
  logic                                 rd_pres_r;

  // overlap stage
  logic                                 s2_v_r, s2_hit_r, s2_ltx_r, s2_ltz_r;
  apor_pkg::wide_t                      s2_ox_r, s2_oz_r;
  logic                                 s1_hit;
  apor_pkg::wide_t                      s1_ox, s1_oz, ax, bx, az, bz;

  // best-hit stage
  logic                                 phit_r;
  apor_pkg::wide_t                      best_r, push_x_r, push_z_r;
  logic                                 take_x, better;
  apor_pkg::wide_t                      pen;

  assign waddr = apor_pkg::ADDR_BITS'(in_entry_index);
  assign wr_ok = cmd.wr && (32'(in_entry_index) < apor_pkg::TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= apor_pkg::LEFT_RST;
      right_r <= apor_pkg::RIGHT_RST;
      near_r  <= apor_pkg::NEAR_RST;
      far_r   <= apor_pkg::FAR_RST;
    end else if (cfg_we) begin
      case (apor_pkg::cfg_idx_t'(cfg_index))
        apor_pkg::CFG_LEFT:  left_r  <= $signed(cfg_wdata);
        apor_pkg::CFG_RIGHT: right_r <= cfg_wdata;
        apor_pkg::CFG_NEAR:  near_r  <= $signed(cfg_wdata);
        apor_pkg::CFG_FAR:   far_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      geo_mem[waddr] <= '{cx: in_box_center_x, cz: in_box_center_z,
                          minx: in_box_min_x, maxx: in_box_max_x,
                          minz: in_box_min_z, maxz: in_box_max_z};
    end
    if (cmd.rd) begin
      rd_q_r <= geo_mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (wr_ok) begin
      present_r[waddr] <= in_entry_present;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_pres_r <= present_r[cmd.addr];
    end
  end

  // overlap test against the current pass's player box
  always_comb begin
    ax = apor_pkg::sext_coord(pmaxx_r) - apor_pkg::sext_coord(rd_q_r.minx);
    bx = apor_pkg::sext_coord(rd_q_r.maxx) - apor_pkg::sext_coord(pminx_r);
    az = apor_pkg::sext_coord(pmaxz_r) - apor_pkg::sext_coord(rd_q_r.minz);
    bz = apor_pkg::sext_coord(rd_q_r.maxz) - apor_pkg::sext_coord(pminz_r);
    s1_ox = (ax < bx) ? ax : bx;
    s1_oz = (az < bz) ? az : bz;
    s1_hit = rd_pres_r &&
             !(pminx_r > rd_q_r.maxx) && !(pmaxx_r < rd_q_r.minx) &&
             !(pminz_r > rd_q_r.maxz) && !(pmaxz_r < rd_q_r.minz);
  end

  always_ff @(posedge clk) begin
    s2_ox_r  <= s1_ox;
    s2_oz_r  <= s1_oz;
    s2_hit_r <= s1_hit;
    s2_ltx_r <= px_r < rd_q_r.cx;
    s2_ltz_r <= pz_r < rd_q_r.cz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.rd;
      s2_v_r <= s1_v_r;
    end
  end

  // smaller axis wins, ties go to z; strictly smaller penetration replaces best
  assign take_x = s2_ox_r < s2_oz_r;
  assign pen    = take_x ? s2_ox_r : s2_oz_r;
  assign better = s2_v_r && s2_hit_r && (!phit_r || (pen < best_r));

  always_ff @(posedge clk) begin
    if (better) begin
      best_r <= pen;
      if (take_x) begin
        push_x_r <= s2_ltx_r ? -s2_ox_r : s2_ox_r;
        push_z_r <= '0;
      end else begin
        push_x_r <= '0;
        push_z_r <= s2_ltz_r ? -s2_oz_r : s2_oz_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phit_r <= 1'b0;
    end else if (cmd.box) begin
      phit_r <= 1'b0;
    end else if (s2_v_r && s2_hit_r) begin
      phit_r <= 1'b1;
    end
  end

  // player box edges for the pass
  always_ff @(posedge clk) begin
    if (cmd.box) begin
      pminx_r <= apor_pkg::sat_coord(apor_pkg::sext_coord(px_r) +
                 apor_pkg::SUM_BITS'(left_r));
      pmaxx_r <= apor_pkg::sat_coord(apor_pkg::sext_coord(px_r) +
                 $signed({{(apor_pkg::SUM_BITS-apor_pkg::OFF_BITS){1'b0}}, right_r}));
      pminz_r <= apor_pkg::sat_coord(apor_pkg::sext_coord(pz_r) +
                 apor_pkg::SUM_BITS'(near_r));
      pmaxz_r <= apor_pkg::sat_coord(apor_pkg::sext_coord(pz_r) +
                 $signed({{(apor_pkg::SUM_BITS-apor_pkg::OFF_BITS){1'b0}}, far_r}));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= in_player_x;
      pz_r <= in_player_z;
    end else if (cmd.apply && phit_r) begin
      px_r <= apor_pkg::sat_coord(apor_pkg::sext_coord(px_r) + push_x_r);
      pz_r <= apor_pkg::sat_coord(apor_pkg::sext_coord(pz_r) + push_z_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r    <= 1'b0;
      passes_r <= '0;
    end else if (cmd.load) begin
      any_r    <= 1'b0;
      passes_r <= '0;
    end else if (cmd.apply && phit_r) begin
      any_r    <= 1'b1;
      passes_r <= passes_r + 1'b1;
    end
  end

  assign sts.pipe_empty = !s1_v_r && !s2_v_r;
  assign sts.pass_hit   = phit_r;
  assign sts.pass_last  = (passes_r == apor_pkg::PASS_BITS'(apor_pkg::MAX_PASSES - 1));

  assign out_resolved_x  = px_r;
  assign out_resolved_z  = pz_r;
  assign out_hit_any     = any_r;
  assign out_passes_used = passes_r;

  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    passes_r <= apor_pkg::PASS_BITS'(apor_pkg::MAX_PASSES))
    else $error("pass count beyond limit");

  a_any_matches_passes: assert property (@(posedge clk) disable iff (!rst_n)
    any_r == (passes_r != '0))
    else $error("hit flag disagrees with pass count");

  a_best_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> (!s1_v_r && !s2_v_r && !cmd.rd))
    else $error("push applied with table reads in flight");

endmodule

FILE: sv/aabb_push_out_resolver_unit.sv
// ----------------------------------------------------------------------------
// aabb_push_out_resolver_unit
// mode 0: a table write is taken on the start beat, no result, busy stays low;
//   a query runs 1 to 4 passes (setup, 64-slot scan, drain, push) and out_valid
//   follows the push step of the last pass, through the S_DONE state
// queries: one at a time, start is taken only while idle and busy stays high to the result beat; no stall
// reset: sync active-low; clears presence flags, offsets to -256/256/-256/256
// ----------------------------------------------------------------------------
module aabb_push_out_resolver_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // command channel
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_mode,
  input  logic [apor_pkg::IDX_BITS-1:0]          in_entry_index,
  input  logic                                   in_entry_present,
  input  logic signed [apor_pkg::COORD_BITS-1:0] in_box_center_x,
  input  logic signed [apor_pkg::COORD_BITS-1:0] in_box_center_z,
  input  logic signed [apor_pkg::COORD_BITS-1:0] in_box_min_x,
  input  logic signed [apor_pkg::COORD_BITS-1:0] in_box_max_x,
  input  logic signed [apor_pkg::COORD_BITS-1:0] in_box_min_z,
  input  logic signed [apor_pkg::COORD_BITS-1:0] in_box_max_z,
  input  logic signed [apor_pkg::COORD_BITS-1:0] in_player_x,
  input  logic signed [apor_pkg::COORD_BITS-1:0] in_player_z,
  // result channel, one beat per query
  output logic                                   out_valid,
  output logic signed [apor_pkg::COORD_BITS-1:0] out_resolved_x,
  output logic signed [apor_pkg::COORD_BITS-1:0] out_resolved_z,
  output logic                                   out_hit_any,
  output logic [apor_pkg::PASS_BITS-1:0]         out_passes_used,
  // configuration write port
  input  logic                                   cfg_we,
  input  logic [apor_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [apor_pkg::OFF_BITS-1:0]          cfg_wdata
);

  // command and status between sequencer and datapath
  apor_pkg::ctrl_cmd_t cmd;
  apor_pkg::ctrl_sts_t sts;

  // sequencer: accepts beats, walks the table once per pass, decides
  // whether another pass follows
  apor_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_mode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // datapath: table memory, overlap pipeline, best hit and push arithmetic;
  // result fields hold the last query's answer and are qualified by out_valid
  apor_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_entry_index   (in_entry_index),
    .in_entry_present (in_entry_present),
    .in_box_center_x  (in_box_center_x),
    .in_box_center_z  (in_box_center_z),
    .in_box_min_x     (in_box_min_x),
    .in_box_max_x     (in_box_max_x),
    .in_box_min_z     (in_box_min_z),
    .in_box_max_z     (in_box_max_z),
    .in_player_x      (in_player_x),
    .in_player_z      (in_player_z),
    .out_resolved_x   (out_resolved_x),
    .out_resolved_z   (out_resolved_z),
    .out_hit_any      (out_hit_any),
    .out_passes_used  (out_passes_used)
  );

endmodule
